// ===== rtl/assert_macros.svh =====
// Assertion helpers for the RTL. Every check is clocked on clk and
// is switched off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold in the same cycle.
`define ASSERT_NOW(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition that must be followed by a consequence in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/bbal_pkg.sv =====
package bbal_pkg;

  localparam int WORD_BITS         = 64;
  localparam int BIT_IDX_W         = 6;
  localparam int BITMAP_WORDS_DEF  = 4;
  localparam int MAX_RUN_DEF       = 16;

  localparam int ADDR_W            = 48;
  localparam int HDR_W             = 16;
  localparam int BSIZE_W           = 17;
  localparam int LEN_W             = 24;
  localparam int COUNT_IN_W        = 5;
  localparam int CFG_IDX_W         = 2;

  localparam logic [BSIZE_W-1:0] BSIZE_RESET = 17'd4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_ADDRESS  = 2'd0,
    CFG_HEADER_OFFSET = 2'd1,
    CFG_BUFFER_SIZE   = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_SCAN,
    ST_ADDR,
    ST_SEND
  } alloc_state_t;

endpackage

// ===== rtl/bitmap_buffer_allocator_unit.sv =====
// Channel    Direction  Handshake              Payload
// request    in         in_valid / in_ready    request_length, max_buffers
// result     out        out_valid / out_ready  buffer_address, buffer_length,
//                                              remaining_length, granted, last
// config     in         cfg_write              cfg_index, cfg_data
//
// One request is handled at a time. After it is accepted, the READ and LOAD
// states fetch the first bitmap word from the RAM. Each granted buffer passes
// through the scan, address add and present states, and an output stall holds
// it in the last of them. Each move to the next bitmap word adds the scan that
// finds the word full and then the READ and LOAD states again.
// Reset marks every bitmap word invalid, which reads as all free, so no
// clearing pass is needed; the configuration registers return to their
// defaults. A stalled result simply holds the sequencer in its send state.
`include "assert_macros.svh"

module bitmap_buffer_allocator_unit
  import bbal_pkg::*;
#(
  parameter int BITMAP_WORDS = BITMAP_WORDS_DEF,
  parameter int MAX_RUN      = MAX_RUN_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [LEN_W-1:0]      request_length,
  input  logic [COUNT_IN_W-1:0] max_buffers,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ADDR_W-1:0]     buffer_address,
  output logic [BSIZE_W-1:0]    buffer_length,
  output logic [LEN_W-1:0]      remaining_length,
  output logic                  granted,
  output logic                  last,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [ADDR_W-1:0]     cfg_data
);

  localparam int WW     = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
  localparam int CNT_W  = $clog2(MAX_RUN + 1);
  localparam int IDX_W  = WW + BIT_IDX_W;
  localparam int PROD_W = BSIZE_W + IDX_W;

  // Configuration registers.
  logic [ADDR_W-1:0]  base_addr;
  logic [HDR_W-1:0]   hdr_offset;
  logic [BSIZE_W-1:0] buf_size;

  // Sequencer and request context.
  alloc_state_t             state, state_next;
  logic [LEN_W-1:0]         len;
  logic [CNT_W-1:0]         limit;
  logic [CNT_W-1:0]         count;
  logic [WW-1:0]            word_idx;
  logic [WORD_BITS-1:0]     word_bits;
  logic [BITMAP_WORDS-1:0]  word_valid;
  logic [PROD_W-1:0]        product;

  // RAM interface.
  logic                 mem_we;
  logic [WW-1:0]        mem_raddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [WORD_BITS-1:0] mem_rdata;

  // Scan results for the word being worked on.
  logic [CNT_W-1:0]     limit_in;
  logic                 word_full;
  logic                 last_word;
  logic [BIT_IDX_W-1:0] free_bit;
  logic [WORD_BITS-1:0] word_taken;
  logic [BSIZE_W-1:0]   take_len;
  logic [LEN_W-1:0]     len_after;
  logic [CNT_W-1:0]     count_after;
  logic                 run_done;

  // Position of the lowest clear bit; only used when the word has one.
  function automatic logic [BIT_IDX_W-1:0] lowest_zero(input logic [WORD_BITS-1:0] w);
    logic [BIT_IDX_W-1:0] b;
    b = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!w[i]) begin
        b = BIT_IDX_W'(i);
      end
    end
    return b;
  endfunction

  bbal_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (BITMAP_WORDS)
  ) u_bitmap_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (word_idx),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // A zero count still takes one buffer; a large count saturates.
  always_comb begin
    if (max_buffers == '0) begin
      limit_in = CNT_W'(1);
    end else if (32'(max_buffers) > MAX_RUN) begin
      limit_in = CNT_W'(MAX_RUN);
    end else begin
      limit_in = CNT_W'(max_buffers);
    end
  end

  // The buffer covers the smaller of the uncovered length and its size.
  // The request finishes once nothing is left or the count is used up.
  always_comb begin
    word_full   = &word_bits;
    last_word   = (word_idx == WW'(BITMAP_WORDS - 1));
    free_bit    = lowest_zero(word_bits);
    word_taken  = word_bits | (WORD_BITS'(1) << free_bit);
    take_len    = (len < LEN_W'(buf_size)) ? BSIZE_W'(len) : buf_size;
    len_after   = len - LEN_W'(take_len);
    count_after = count + CNT_W'(1);
    run_done    = (len_after == '0) || (count_after == limit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_addr  <= '0;
      hdr_offset <= '0;
      buf_size   <= BSIZE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_BASE_ADDRESS:  base_addr  <= cfg_data;
        CFG_HEADER_OFFSET: hdr_offset <= cfg_data[HDR_W-1:0];
        CFG_BUFFER_SIZE:   buf_size   <= cfg_data[BSIZE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    mem_we     = 1'b0;
    mem_raddr  = word_idx;
    mem_wdata  = word_taken;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (!word_full) begin
          mem_we     = 1'b1;
          state_next = ST_ADDR;
        end else if (last_word) begin
          state_next = ST_SEND;
        end else begin
          state_next = ST_READ;
        end
      end
      ST_ADDR: begin
        state_next = ST_SEND;
      end
      ST_SEND: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = last ? ST_IDLE : ST_SCAN;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Words never written since reset read as all free.
  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= '0;
    end else if (mem_we) begin
      word_valid[word_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          len      <= request_length;
          limit    <= limit_in;
          count    <= '0;
          word_idx <= '0;
        end
      end
      ST_LOAD: begin
        word_bits <= word_valid[word_idx] ? mem_rdata : '0;
      end
      ST_SCAN: begin
        if (!word_full) begin
          word_bits        <= word_taken;
          product          <= buf_size * PROD_W'({word_idx, free_bit});
          len              <= len_after;
          count            <= count_after;
          buffer_length    <= take_len;
          remaining_length <= len_after;
          granted          <= 1'b1;
          last             <= run_done;
        end else if (last_word) begin
          // Bitmap exhausted: report what is still uncovered.
          buffer_address   <= '0;
          buffer_length    <= '0;
          remaining_length <= len;
          granted          <= 1'b0;
          last             <= 1'b1;
        end else begin
          word_idx <= word_idx + WW'(1);
        end
      end
      ST_ADDR: begin
        buffer_address <= base_addr + ADDR_W'(hdr_offset) + ADDR_W'(product);
      end
      default: begin
      end
    endcase
  end

  `ASSERT_NOW(a_fail_is_last, !(out_valid && !granted) || last,
              "exhausted result not marked last")
  `ASSERT_NOW(a_idle_no_output, !(in_ready && out_valid),
              "request taken while a result is pending")
  `ASSERT_NEXT(a_last_frees_input, out_valid && out_ready && last, in_ready,
               "block not idle after the final result")
  `ASSERT_NOW(a_full_cover, !(out_valid && granted && !last) || (buffer_length == buf_size),
              "intermediate buffer not fully covered")

endmodule

// ===== rtl/bbal_ram.sv =====
module bbal_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bbal_pkg::*;

  // The pool is a fixed set of equal buffers, and nothing frees them but reset.
  localparam int TOTAL_BUFFERS   = BITMAP_WORDS_DEF * WORD_BITS;
  // The one register index that maps to no register. Writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 56;
  localparam int SETTLE_CYCLES   = 4;    // idle cycles before a register write
  localparam int LONG_HOLD       = 300;  // one long result stall, to back up the block
  localparam int DRAIN_CYCLES    = 20;   // quiet cycles after the last result
  localparam int WATCHDOG_LIMIT  = 2000; // well above the long stall plus block latency
  localparam int PRINT_LIMIT     = 50;

  // One result as the block presents it.
  typedef struct packed {
    logic [ADDR_W-1:0]  address;
    logic [BSIZE_W-1:0] length;
    logic [LEN_W-1:0]   remaining;
    logic               granted;
    logic               last;
  } grant_t;

  // The opening table holds two kinds of rows: a register write and a request.
  typedef enum {STEP_WRITE, STEP_REQUEST} step_kind_t;

  typedef struct {
    step_kind_t           kind;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [ADDR_W-1:0]    reg_value;
    logic [LEN_W-1:0]     length;
    logic [COUNT_IN_W-1:0] count;
    bit                   typed;    // the outcome below is the whole expectation
    grant_t               outcome;
  } plan_step_t;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic [LEN_W-1:0]      request_length;
  logic [COUNT_IN_W-1:0] max_buffers;
  logic                  out_valid;
  logic                  out_ready;
  logic [ADDR_W-1:0]     buffer_address;
  logic [BSIZE_W-1:0]    buffer_length;
  logic [LEN_W-1:0]      remaining_length;
  logic                  granted;
  logic                  last;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [ADDR_W-1:0]     cfg_data;

  bitmap_buffer_allocator_unit DUT (
    .clk, .rst,
    .in_valid, .in_ready, .request_length, .max_buffers,
    .out_valid, .out_ready, .buffer_address, .buffer_length, .remaining_length,
    .granted, .last,
    .cfg_write, .cfg_index, .cfg_data
  );

  // The clock has a 2 ns period, low for the first half.
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // The testbench keeps its own copy of the block's state. The usage map has
  // one bit per buffer, and a set bit means the buffer is in use. The register
  // copies follow every write, masked to the width of each register.
  logic [WORD_BITS-1:0] buffer_map [BITMAP_WORDS_DEF];
  logic [ADDR_W-1:0]    area_base;
  logic [HDR_W-1:0]     header_bytes;
  logic [BSIZE_W-1:0]   slot_bytes;
  int                   buffers_in_use;

  // Results still owed by the block, oldest first.
  grant_t pending_grants[$];
  plan_step_t opening_plan[$];

  int  failures;
  int  requests_sent;
  int  results_seen;
  int  shortfalls;
  int  writes_done;
  bit  offering;
  bit  accepting;
  bit  sender_calm;
  bit  receiver_calm;
  bit  hold_requested;
  int  quiet_cycles;

  // Predicts the buffers that one request takes. The words of the map are
  // scanned in order, and the lowest free bit of a word is taken until that
  // word is full. Each buffer covers as much of the remaining length as it
  // can. The request ends when the length is covered or the buffer count is
  // used up. If the pool runs dry first, one more result with granted low
  // reports the bytes that are still uncovered.
  task automatic allocate_buffers(input logic [LEN_W-1:0] length,
                                  input logic [COUNT_IN_W-1:0] count,
                                  output grant_t produced[$]);
    logic [LEN_W-1:0]   left;
    logic [BSIZE_W-1:0] piece;
    int                 cap;
    int                 taken;
    int                 w;
    int                 b;
    bit                 done;
    grant_t             g;
    produced = {};
    left = length;
    cap = (count == 0) ? 1 : int'(count);
    if (cap > MAX_RUN_DEF) cap = MAX_RUN_DEF;
    taken = 0;
    done = 1'b0;
    for (w = 0; w < BITMAP_WORDS_DEF && !done; w++) begin
      while (!done && buffer_map[w] != '1) begin
        b = 0;
        while (buffer_map[w][b]) b++;
        piece = (left < slot_bytes) ? BSIZE_W'(left) : slot_bytes;
        g.address = area_base + ADDR_W'(header_bytes) +
                    ADDR_W'(slot_bytes) * ADDR_W'(w * WORD_BITS + b);
        buffer_map[w][b] = 1'b1;
        left = left - LEN_W'(piece);
        taken++;
        buffers_in_use++;
        done = (left == 0) || (taken == cap);
        g.length = piece;
        g.remaining = left;
        g.granted = 1'b1;
        g.last = done;
        produced.push_back(g);
      end
    end
    if (!done) begin
      g = '0;
      g.remaining = left;
      g.last = 1'b1;
      produced.push_back(g);
    end
  endtask

  task automatic plan_write(input logic [CFG_IDX_W-1:0] index, input logic [ADDR_W-1:0] value);
    plan_step_t s;
    s = '{kind: STEP_WRITE, reg_index: index, reg_value: value, default: '0};
    opening_plan.push_back(s);
  endtask

  task automatic plan_request(input logic [LEN_W-1:0] length,
                              input logic [COUNT_IN_W-1:0] count);
    plan_step_t s;
    s = '{kind: STEP_REQUEST, length: length, count: count, default: '0};
    opening_plan.push_back(s);
  endtask

  // A request whose single result is easy to work out by hand.
  task automatic plan_typed(input logic [LEN_W-1:0] length, input logic [COUNT_IN_W-1:0] count,
                            input logic [ADDR_W-1:0] address, input logic [BSIZE_W-1:0] blen,
                            input logic [LEN_W-1:0] remaining);
    plan_step_t s;
    s = '{kind: STEP_REQUEST, length: length, count: count, typed: 1'b1, default: '0};
    s.outcome = '{address: address, length: blen, remaining: remaining,
                  granted: 1'b1, last: 1'b1};
    opening_plan.push_back(s);
  endtask

  // Offers one request and waits for the block to take it. The valid signal
  // drops only when a gap is drawn, so back-to-back requests keep it high.
  // The predictor updates its state when the request is accepted. For typed
  // rows, the value from the table replaces the predicted outcome, but the
  // usage map still advances.
  task automatic offer_request(input logic [LEN_W-1:0] length,
                               input logic [COUNT_IN_W-1:0] count,
                               input bit typed, input grant_t outcome);
    int     gap;
    grant_t produced[$];
    gap = sender_calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      if (offering) begin
        in_valid <= 1'b0;
        offering = 1'b0;
      end
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    offering = 1'b1;
    request_length <= length;
    max_buffers <= count;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    allocate_buffers(length, count, produced);
    if (typed) pending_grants.push_back(outcome);
    else foreach (produced[i]) pending_grants.push_back(produced[i]);
    requests_sent++;
  endtask

  // Registers change only while the block is idle. The sender first stops
  // offering and waits until every owed result has arrived. It then lets the
  // block settle back to idle before the write.
  task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                input logic [ADDR_W-1:0] value);
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
    end
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (index)
      CFG_BASE_ADDRESS:  area_base = value;
      CFG_HEADER_OFFSET: header_bytes = value[HDR_W-1:0];
      CFG_BUFFER_SIZE:   slot_bytes = value[BSIZE_W-1:0];
      default: ;
    endcase
    writes_done++;
  endtask

  // Draws a random request. While the pool has room, most requests take one
  // to three buffers. This keeps the pool alive through several settings.
  // Near and past exhaustion, any length and count may be drawn, so requests
  // also run the pool dry partway through.
  task automatic draw_request(output logic [LEN_W-1:0] length,
                              output logic [COUNT_IN_W-1:0] count);
    int unsigned bs;
    int unsigned pick;
    bs = slot_bytes;
    pick = $urandom_range(0, 9);
    count = COUNT_IN_W'($urandom_range(0, 31));
    length = LEN_W'($urandom);
    if (buffers_in_use + MAX_RUN_DEF >= TOTAL_BUFFERS) begin
      if (pick == 0) length = '0;
    end else if (bs == 0) begin
      // With a zero buffer size, every buffer covers nothing, so only the count limits a request.
      count = COUNT_IN_W'($urandom_range(0, 2));
    end else if (pick == 0) begin
      length = '0;
    end else if (pick <= 6) begin
      length = LEN_W'($urandom_range(1, bs));
    end else if (pick <= 8) begin
      length = LEN_W'($urandom_range(bs + 1, 3 * bs));
      count = COUNT_IN_W'($urandom_range(1, 4));
    end else begin
      count = COUNT_IN_W'($urandom_range(0, 3));
    end
  endtask

  // Prints one line for each mismatch and counts it. Only the first
  // PRINT_LIMIT lines are printed, to keep the log short, but every mismatch
  // is counted.
  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    failures++;
    if (failures <= PRINT_LIMIT)
      $display("MISMATCH at result %0d: %s is 0x%0h, expected 0x%0h",
               results_seen, what, got, want);
  endtask

  // Main sequence: reset, then the opening table, then random phases under
  // several register settings, then the drain at the end of the run.
  initial begin
    int                    phase;
    int                    k;
    logic [LEN_W-1:0]      len;
    logic [COUNT_IN_W-1:0] cnt;
    logic [ADDR_W-1:0]     base_v;
    logic [ADDR_W-1:0]     hdr_v;
    logic [ADDR_W-1:0]     size_v;

    rst <= 1'b1;
    in_valid <= 1'b0;
    request_length <= '0;
    max_buffers <= '0;
    cfg_write <= 1'b0;
    cfg_index <= CFG_BASE_ADDRESS;
    cfg_data <= '0;
    foreach (buffer_map[w]) buffer_map[w] = '0;
    area_base = '0;
    header_bytes = '0;
    slot_bytes = BSIZE_RESET;
    buffers_in_use = 0;
    failures = 0;
    requests_sent = 0;
    writes_done = 0;
    offering = 1'b0;
    sender_calm = 1'b0;
    receiver_calm = 1'b0;
    hold_requested = 1'b0;

    // Opening table. The first rows run with the reset settings, so their
    // addresses are plain multiples of 4096.
    plan_typed(24'd0, 5'd1, 48'd0, 17'd0, 24'd0);            // zero length still takes a buffer
    plan_typed(24'd4096, 5'd1, 48'd4096, 17'd4096, 24'd0);   // exactly one full buffer
    plan_request(24'd10000, 5'd16);                          // spans three buffers
    plan_typed(24'hFFFFFF, 5'd0, 48'd20480, 17'd4096, 24'hFFEFFF); // zero count acts as one
    plan_request(24'hFFFFFF, 5'd31);                         // count saturates at sixteen
    plan_typed(24'd1, 5'd16, 48'd90112, 17'd1, 24'd0);
    // Largest base and offset, and a size of 65536. The address wraps at 48 bits, and the
    // upper data bits must be masked off.
    plan_write(CFG_BASE_ADDRESS, 48'hFFFF_FFFF_FFFF);
    plan_write(CFG_HEADER_OFFSET, 48'hFFFF_FFFF_FFFF);
    plan_write(CFG_BUFFER_SIZE, 48'h0000_0001_0000);
    plan_request(24'hFFFFFF, 5'd2);
    plan_request(24'd65536, 5'd1);
    // A buffer size of zero hidden under set upper bits, then a write to the
    // unmapped index, which must leave the size at zero.
    plan_write(CFG_BUFFER_SIZE, 48'hFFFF_FFFE_0000);
    plan_write(CFG_UNMAPPED, 48'hAAAA_5555_0005);
    plan_request(24'd100, 5'd3);
    plan_request(24'd0, 5'd2);
    // Smallest nonzero size with no base and no offset.
    plan_write(CFG_BASE_ADDRESS, 48'd0);
    plan_write(CFG_HEADER_OFFSET, 48'd0);
    plan_write(CFG_BUFFER_SIZE, 48'd1);
    plan_request(24'd2, 5'd16);
    plan_request(24'd0, 5'd31);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (opening_plan[i]) begin
      if (opening_plan[i].kind == STEP_WRITE)
        write_register(opening_plan[i].reg_index, opening_plan[i].reg_value);
      else
        offer_request(opening_plan[i].length, opening_plan[i].count,
                      opening_plan[i].typed, opening_plan[i].outcome);
    end

    // Random phases. Each phase starts with a fresh setting, and the sender
    // waits for the block to drain before the writes. The first phases use
    // the extreme settings. One phase runs a zero buffer size, and the rest
    // use random values with random upper data bits.
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      base_v = ADDR_W'({$urandom, $urandom});
      hdr_v = ADDR_W'({$urandom, $urandom});
      size_v = ADDR_W'({$urandom, $urandom});
      size_v[BSIZE_W-1:0] = BSIZE_W'($urandom_range(1, 65536));
      case (phase)
        0: begin
          base_v = '1;
          hdr_v = '1;
          size_v[BSIZE_W-1:0] = 17'h10000;
        end
        1: begin
          base_v = '0;
          hdr_v[HDR_W-1:0] = '0;
          size_v[BSIZE_W-1:0] = 17'd1;
        end
        4: size_v[BSIZE_W-1:0] = '0;
        default: ;
      endcase
      write_register(CFG_BASE_ADDRESS, base_v);
      write_register(CFG_HEADER_OFFSET, hdr_v);
      write_register(CFG_BUFFER_SIZE, size_v);
      write_register(CFG_UNMAPPED, ADDR_W'({$urandom, $urandom}));

      // Phase 2 runs with no idling on either side. In other phases, each
      // side sometimes turns its gaps off.
      sender_calm = (phase == 2) || ($urandom_range(0, 4) == 0);
      receiver_calm = (phase == 2) || ($urandom_range(0, 4) == 0);

      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        // Early in the second phase, the receiver stalls for a long time while
        // the sender keeps offering requests. This backs up the block.
        if (phase == 1 && k == 10) hold_requested = 1'b1;
        draw_request(len, cnt);
        offer_request(len, cnt, 1'b0, '0);
      end
    end

    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
    end
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d requests (%0d from the opening table) and %0d results,",
             requests_sent, 12, results_seen);
    $display("%0d of them reporting an empty pool; %0d register writes; %0d of %0d buffers taken.",
             shortfalls, writes_done, buffers_in_use, TOTAL_BUFFERS);
    if (failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Result side. Before each result, the receiver draws a stall. A long
  // hold-off is taken once, when the sender asks for it. Each accepted result
  // is checked, field by field, against the oldest expectation.
  initial begin
    int     stall;
    grant_t want;
    out_ready <= 1'b0;
    accepting = 1'b0;
    results_seen = 0;
    shortfalls = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = receiver_calm ? 0 : $urandom_range(0, 11);
      if (hold_requested) begin
        hold_requested = 1'b0;
        stall = LONG_HOLD;
      end
      if (stall > 0) begin
        if (accepting) begin
          out_ready <= 1'b0;
          accepting = 1'b0;
        end
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      accepting = 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      results_seen++;
      if (granted === 1'b0) shortfalls++;
      if (pending_grants.size() == 0) begin
        report_mismatch("unrequested result, buffer_address", buffer_address, 0);
      end else begin
        want = pending_grants.pop_front();
        if (buffer_address !== want.address)
          report_mismatch("buffer_address", buffer_address, want.address);
        if (buffer_length !== want.length)
          report_mismatch("buffer_length", buffer_length, want.length);
        if (remaining_length !== want.remaining)
          report_mismatch("remaining_length", remaining_length, want.remaining);
        if (granted !== want.granted)
          report_mismatch("granted", granted, want.granted);
        if (last !== want.last)
          report_mismatch("last", last, want.last);
      end
    end
  end

  // Watchdog. A correct run never goes longer than the long hold-off plus the
  // block latency without a handshake on either channel.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles, %0d results still owed",
               WATCHDOG_LIMIT, pending_grants.size());
      $display("FAILURE");
      $finish;
    end
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/bbal_pkg.sv
rtl/bbal_ram.sv
rtl/bitmap_buffer_allocator_unit.sv
bench/tb_top.sv
